FILE: rtl/core/wegs_pkg.sv
package wegs_pkg;

    // Default grid and sine table sizes.
    localparam int GridSizeDef    = 64;
    localparam int SineEntriesDef = 1024;

    // Fixed field widths.
    localparam int FieldW  = 6;
    localparam int DataW   = 32;
    localparam int AmpW    = 25;
    localparam int CfgIdxW = 3;

    // Request function codes.
    localparam logic FUNC_ADVANCE = 1'b0;
    localparam logic FUNC_READ    = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CfgIdxW-1:0] {
        CFG_TIME_STEP    = 3'd0,
        CFG_COUPLING     = 3'd1,
        CFG_DRIVE_AMP    = 3'd2,
        CFG_SOURCE_ROW   = 3'd3,
        CFG_SOURCE_FIRST = 3'd4,
        CFG_SOURCE_LAST  = 3'd5
    } cfg_index_t;

    // Configuration reset values.
    localparam logic [DataW-1:0]  TIME_STEP_RST    = 32'd715828;
    localparam logic [DataW-1:0]  COUPLING_RST     = 32'd98040000;
    localparam logic [AmpW-1:0]   DRIVE_AMP_RST    = 25'd838861;
    localparam logic [FieldW-1:0] SOURCE_ROW_RST   = 6'd10;
    localparam logic [FieldW-1:0] SOURCE_FIRST_RST = 6'd5;
    localparam logic [FieldW-1:0] SOURCE_LAST_RST  = 6'd35;

    // Fixed-point constants for the sine table.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    // Controller states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PHASE,
        ST_SINE_A,
        ST_SINE_B,
        ST_SINE_C,
        ST_SWEEP,
        ST_DRAIN,
        ST_RD_ISSUE,
        ST_RD_LOAD,
        ST_OUT
    } wegs_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic capture;
        logic phase_step;
        logic sweep;
        logic out_load;
    } wegs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic sweep_last;
        logic pipe_empty;
    } wegs_status_t;

    // Saturate a wide signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] res;
        if (v > 40'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end
        else if (v < -40'sd2147483648) begin
            res = 32'sh80000000;
        end
        else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // Sine of a 32-bit turn fraction in Q2.30, folded to a quarter wave and
    // evaluated with a truncated Taylor series. Used to build the constant table.
    function automatic logic signed [31:0] sine_q30(input logic [31:0] f);
        logic [1:0]         q;
        logic [63:0]        r;
        logic [63:0]        t;
        logic [63:0]        t2;
        logic [63:0]        a;
        logic [63:0]        s;
        logic signed [31:0] res;
        q = f[31:30];
        r = {34'd0, f[29:0]};
        if (q[0]) begin
            r = ONE_Q30 - r;
        end
        t  = (r * HALF_PI_Q30) >> 30;
        t2 = (t * t) >> 30;
        a  = ONE_Q30 - t2 / 64'd72;
        a  = ONE_Q30 - ((t2 * a) >> 30) / 64'd42;
        a  = ONE_Q30 - ((t2 * a) >> 30) / 64'd20;
        a  = ONE_Q30 - ((t2 * a) >> 30) / 64'd6;
        s  = (t * a) >> 30;
        if (s > ONE_Q30) begin
            s = ONE_Q30;
        end
        res = signed'(s[31:0]);
        if (q[1]) begin
            res = -res;
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/wegs_if.sv
// Request channel: function code and cell address.
interface wegs_req_if;
    import wegs_pkg::*;

    logic              valid;
    logic              ready;
    logic              func;
    logic [FieldW-1:0] row;
    logic [FieldW-1:0] col;

    modport source(output valid, output func, output row, output col, input ready);
    modport sink(input valid, input func, input row, input col, output ready);
endinterface

// Response channel: height and rate of one cell.
interface wegs_rsp_if;
    import wegs_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [DataW-1:0] height;
    logic signed [DataW-1:0] rate;

    modport source(output valid, output height, output rate, input ready);
    modport sink(input valid, input height, input rate, output ready);
endinterface

FILE: rtl/core/wegs_ram.sv
module wegs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/wegs_ctrl.sv
module wegs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_func,
    input  logic                  out_ready,
    input  wegs_pkg::wegs_status_t status,
    output wegs_pkg::wegs_cmd_t    cmd,
    output logic                  in_ready,
    output logic                  out_valid
);
    import wegs_pkg::*;

    wegs_state_t state_reg;
    wegs_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_func == FUNC_READ) ? ST_RD_ISSUE : ST_PHASE;
                end
            end
            ST_PHASE:    state_next = ST_SINE_A;
            ST_SINE_A:   state_next = ST_SINE_B;
            ST_SINE_B:   state_next = ST_SINE_C;
            ST_SINE_C:   state_next = ST_SWEEP;
            ST_SWEEP:
            begin
                if (status.sweep_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (status.pipe_empty)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_RD_ISSUE: state_next = ST_RD_LOAD;
            ST_RD_LOAD:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_CLEAR;
        endcase
    end

    // Outputs decoded from the state.
    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_CLEAR:   cmd.clear = 1'b1;
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_PHASE:   cmd.phase_step = 1'b1;
            ST_SWEEP:   cmd.sweep = 1'b1;
            ST_RD_LOAD: cmd.out_load = 1'b1;
            ST_OUT:     out_valid = 1'b1;
            default:    cmd = '0;
        endcase
    end

endmodule

FILE: rtl/core/wegs_dp.sv
module wegs_dp #(
    parameter int GRID_SIZE    = wegs_pkg::GridSizeDef,
    parameter int SINE_ENTRIES = wegs_pkg::SineEntriesDef
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [wegs_pkg::CfgIdxW-1:0]        cfg_index,
    input  logic [wegs_pkg::DataW-1:0]          cfg_data,
    input  logic [wegs_pkg::FieldW-1:0]         row,
    input  logic [wegs_pkg::FieldW-1:0]         col,
    input  wegs_pkg::wegs_cmd_t                 cmd,
    output wegs_pkg::wegs_status_t              status,
    output logic signed [wegs_pkg::DataW-1:0]   height,
    output logic signed [wegs_pkg::DataW-1:0]   rate
);
    import wegs_pkg::*;

    localparam int Cells   = GRID_SIZE * GRID_SIZE;
    localparam int AW      = $clog2(Cells);
    localparam int CntW    = $clog2(Cells + GRID_SIZE);
    localparam int IW      = $clog2(SINE_ENTRIES);
    localparam int RW      = $clog2(GRID_SIZE);
    localparam int LineLen = 2 * GRID_SIZE + 1;
    localparam int LapW    = 36;
    localparam int CmpW    = 9;

    // Configuration registers.
    logic [DataW-1:0]  ts_reg;
    logic [DataW-1:0]  cp_reg;
    logic [AmpW-1:0]   amp_reg;
    logic [FieldW-1:0] src_row_reg;
    logic [FieldW-1:0] src_first_reg;
    logic [FieldW-1:0] src_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg        <= TIME_STEP_RST;
            cp_reg        <= COUPLING_RST;
            amp_reg       <= DRIVE_AMP_RST;
            src_row_reg   <= SOURCE_ROW_RST;
            src_first_reg <= SOURCE_FIRST_RST;
            src_last_reg  <= SOURCE_LAST_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_TIME_STEP:    ts_reg        <= cfg_data;
                CFG_COUPLING:     cp_reg        <= cfg_data;
                CFG_DRIVE_AMP:    amp_reg       <= cfg_data[AmpW-1:0];
                CFG_SOURCE_ROW:   src_row_reg   <= cfg_data[FieldW-1:0];
                CFG_SOURCE_FIRST: src_first_reg <= cfg_data[FieldW-1:0];
                CFG_SOURCE_LAST:  src_last_reg  <= cfg_data[FieldW-1:0];
                default:          ts_reg        <= ts_reg;
            endcase
        end
    end

    // Time phase.
    logic [DataW-1:0] phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (cmd.phase_step)
        begin
            phase_reg <= phase_reg + ts_reg;
        end
    end

    // Sine table, built at elaboration.
    logic signed [DataW-1:0] sine_rom [SINE_ENTRIES];

    for (genvar g = 0; g < SINE_ENTRIES; g++)
    begin : g_sine
        localparam logic [63:0] FPos = (64'(g) << 32) / SINE_ENTRIES;
        assign sine_rom[g] = sine_q30(FPos[31:0]);
    end

    // Source value: table index, table read, amplitude scaling.
    logic [63:0]             idx_full;
    logic [IW-1:0]           sine_idx_reg;
    logic signed [DataW-1:0] sine_reg;
    logic signed [57:0]      src_prod;
    logic signed [57:0]      src_sum;
    logic signed [DataW-1:0] src_reg;

    assign idx_full = 64'(phase_reg) * 64'(SINE_ENTRIES);
    assign src_prod = signed'({1'b0, amp_reg}) * sine_reg;
    assign src_sum  = src_prod + 58'sd536870912;

    always_ff @(posedge clk)
    begin
        sine_idx_reg <= idx_full[32 +: IW];
        sine_reg     <= sine_rom[sine_idx_reg];
        src_reg      <= {{4{src_sum[57]}}, src_sum[57:30]};
    end

    // Sweep and clear address counter.
    logic [CntW-1:0] addr_reg;
    logic            clear_last;
    logic            sweep_last;
    logic            center;
    logic [RW-1:0]   ci_reg;
    logic [RW-1:0]   cj_reg;

    assign clear_last = addr_reg == CntW'(Cells - 1);
    assign sweep_last = addr_reg == CntW'(Cells + GRID_SIZE - 1);
    assign center     = cmd.sweep && (addr_reg >= CntW'(GRID_SIZE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
            ci_reg   <= '0;
            cj_reg   <= '0;
        end
        else
        begin
            if ((cmd.clear && clear_last) || (cmd.sweep && sweep_last))
            begin
                addr_reg <= '0;
            end
            else if (cmd.clear || cmd.sweep)
            begin
                addr_reg <= addr_reg + 1'b1;
            end
            // Row and column of the cell at the center of the window.
            if (cmd.sweep && sweep_last)
            begin
                ci_reg <= '0;
                cj_reg <= '0;
            end
            else if (center)
            begin
                if (cj_reg == RW'(GRID_SIZE - 1))
                begin
                    cj_reg <= '0;
                    ci_reg <= ci_reg + 1'b1;
                end
                else
                begin
                    cj_reg <= cj_reg + 1'b1;
                end
            end
        end
    end

    // Captured read address.
    logic [AW-1:0] rd_k_reg;
    logic          rd_ok_reg;

    // Memories.
    logic [AW-1:0]    h_raddr;
    logic [AW-1:0]    r_raddr;
    logic [DataW-1:0] h_rdata;
    logic [DataW-1:0] r_rdata;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [DataW-1:0] h_wdata;
    logic [DataW-1:0] r_wdata;

    assign h_raddr = cmd.sweep ? addr_reg[AW-1:0] : rd_k_reg;
    assign r_raddr = cmd.sweep ? AW'(addr_reg - CntW'(GRID_SIZE)) : rd_k_reg;

    wegs_ram #(.WIDTH(DataW), .DEPTH(Cells)) u_heights (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (h_wdata),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    wegs_ram #(.WIDTH(DataW), .DEPTH(Cells)) u_rates (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (r_wdata),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    // Pipeline valid bits.
    logic p1_v_reg;
    logic p2_v_reg;
    logic p3_v_reg;
    logic p4_v_reg;
    logic p5_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
            p4_v_reg <= 1'b0;
            p5_v_reg <= 1'b0;
        end
        else
        begin
            p1_v_reg <= center;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            p4_v_reg <= p3_v_reg;
            p5_v_reg <= p4_v_reg;
        end
    end

    assign status.clear_last = clear_last;
    assign status.sweep_last = sweep_last;
    assign status.pipe_empty = !(p1_v_reg || p2_v_reg || p3_v_reg || p4_v_reg || p5_v_reg);

    // Old heights stream through a line of two rows plus one.
    logic signed [DataW-1:0] sh_reg [LineLen];

    always_ff @(posedge clk)
    begin
        sh_reg[0] <= h_rdata;
        for (int n = 1; n < LineLen; n++)
        begin
            sh_reg[n] <= sh_reg[n-1];
        end
    end

    // Stage payloads.
    logic [RW-1:0]           p1_i_reg, p1_j_reg, p2_i_reg, p2_j_reg;
    logic [AW-1:0]           p1_k_reg, p2_k_reg, p3_k_reg, p4_k_reg, p5_k_reg;
    logic signed [DataW-1:0] p2_rate_reg;
    logic signed [LapW-1:0]  p3_lap_reg;
    logic signed [DataW-1:0] p3_h_reg, p3_rate_reg, p4_h_reg, p4_rate_reg;
    logic signed [DataW-1:0] p5_h_reg, p5_rate_reg;
    logic                    p3_drv_reg, p4_drv_reg, p5_drv_reg;
    logic                    p3_edge_reg, p4_edge_reg, p5_edge_reg;
    logic signed [63:0]      p4_tsr_reg;
    logic signed [52:0]      p4_pa_reg;
    logic signed [52:0]      p4_pb_reg;
    logic signed [DataW-1:0] p5_hterm_reg;
    logic signed [37:0]      p5_rterm_reg;

    // Laplacian around the window center.
    logic signed [LapW-1:0] self_w, up_w, dn_w, lf_w, rt_w;
    logic signed [LapW-1:0] lap;
    logic                   driven;
    logic                   edge_row;

    assign self_w = LapW'(sh_reg[GRID_SIZE]);
    assign up_w   = LapW'(sh_reg[2*GRID_SIZE]);
    assign dn_w   = LapW'(sh_reg[0]);
    assign lf_w   = LapW'(sh_reg[GRID_SIZE+1]);
    assign rt_w   = LapW'(sh_reg[GRID_SIZE-1]);

    always_comb
    begin
        lap = up_w + dn_w - (self_w <<< 1);
        if (p2_j_reg == '0)
        begin
            lap = lap + rt_w - self_w;
        end
        else if (p2_j_reg == RW'(GRID_SIZE - 1))
        begin
            lap = lap + lf_w - self_w;
        end
        else
        begin
            lap = lap + lf_w + rt_w - (self_w <<< 1);
        end
    end

    assign driven = (CmpW'(p2_i_reg) == CmpW'(src_row_reg))
                 && (CmpW'(p2_j_reg) >= CmpW'(src_first_reg))
                 && (CmpW'(p2_j_reg) <= CmpW'(src_last_reg));
    assign edge_row = (p2_i_reg == '0) || (p2_i_reg == RW'(GRID_SIZE - 1));

    // Rounding of the scaled products.
    logic signed [63:0] h_sum;
    logic signed [53:0] pb_sum;
    logic signed [53:0] r_sum;

    assign h_sum  = p4_tsr_reg + 64'sd2147483648;
    assign pb_sum = 54'(p4_pb_reg) + 54'sd2147483648;
    assign r_sum  = 54'(p4_pa_reg) + 54'($signed(pb_sum[53:16]));

    always_ff @(posedge clk)
    begin
        // Read data arrives.
        p1_i_reg    <= ci_reg;
        p1_j_reg    <= cj_reg;
        p1_k_reg    <= AW'(addr_reg - CntW'(GRID_SIZE));
        // Window aligned on the center.
        p2_i_reg    <= p1_i_reg;
        p2_j_reg    <= p1_j_reg;
        p2_k_reg    <= p1_k_reg;
        p2_rate_reg <= r_rdata;
        // Laplacian and cell flags.
        p3_k_reg    <= p2_k_reg;
        p3_lap_reg  <= lap;
        p3_h_reg    <= sh_reg[GRID_SIZE];
        p3_rate_reg <= p2_rate_reg;
        p3_drv_reg  <= driven;
        p3_edge_reg <= edge_row;
        // Products.
        p4_k_reg    <= p3_k_reg;
        p4_tsr_reg  <= signed'({1'b0, ts_reg}) * p3_rate_reg;
        p4_pa_reg   <= signed'({1'b0, cp_reg[31:16]}) * p3_lap_reg;
        p4_pb_reg   <= signed'({1'b0, cp_reg[15:0]}) * p3_lap_reg;
        p4_h_reg    <= p3_h_reg;
        p4_rate_reg <= p3_rate_reg;
        p4_drv_reg  <= p3_drv_reg;
        p4_edge_reg <= p3_edge_reg;
        // Rounded increments.
        p5_k_reg     <= p4_k_reg;
        p5_hterm_reg <= h_sum[63:32];
        p5_rterm_reg <= r_sum[53:16];
        p5_h_reg     <= p4_h_reg;
        p5_rate_reg  <= p4_rate_reg;
        p5_drv_reg   <= p4_drv_reg;
        p5_edge_reg  <= p4_edge_reg;
    end

    // Final sums with saturation, or the source on driven cells and a zero rate on edge rows, written back in place.
    logic signed [DataW-1:0] h_new;
    logic signed [DataW-1:0] r_new;

    assign h_new = p5_drv_reg ? src_reg
                 : sat32(40'(p5_h_reg) + 40'(p5_hterm_reg));
    assign r_new = p5_edge_reg ? '0
                 : sat32(40'(p5_rate_reg) + 40'(p5_rterm_reg));

    assign mem_we    = cmd.clear || p5_v_reg;
    assign mem_waddr = cmd.clear ? addr_reg[AW-1:0] : p5_k_reg;
    assign h_wdata   = cmd.clear ? '0 : h_new;
    assign r_wdata   = cmd.clear ? '0 : r_new;

    // Read capture and output registers.
    logic signed [DataW-1:0] out_h_reg;
    logic signed [DataW-1:0] out_r_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rd_k_reg  <= AW'(int'(row) * GRID_SIZE + int'(col));
            rd_ok_reg <= (CmpW'(row) < CmpW'(GRID_SIZE)) && (CmpW'(col) < CmpW'(GRID_SIZE));
            out_h_reg <= '0;
            out_r_reg <= '0;
        end
        else if (cmd.out_load && rd_ok_reg)
        begin
            out_h_reg <= h_rdata;
            out_r_reg <= r_rdata;
        end
    end

    assign height = out_h_reg;
    assign rate   = out_r_reg;

endmodule

FILE: rtl/core/wave_equation_grid_step.sv
// Explicit 2D wave-equation stepper on a GRID_SIZE x GRID_SIZE grid of Q8.24
// heights and rates. After reset a clearing pass writes zero to every cell,
// during which no item is accepted. One item is in work at a time. A read
// item issues the memory read, loads the output registers and then shows the
// result. An advance item steps the phase and forms the source sine, then
// the cell sweep streams every height through the single read port of the
// height memory, one cell per cycle, plus one row of lead-in to fill the row
// line, and then the update pipeline drains. Configuration writes are taken
// on any cycle but should be made only while the block is idle.
module wave_equation_grid_step #(
    parameter int GRID_SIZE    = wegs_pkg::GridSizeDef,
    parameter int SINE_ENTRIES = wegs_pkg::SineEntriesDef
) (
    input  logic                         clk,
    input  logic                         rst_n,
    wegs_req_if.sink                     request,
    wegs_rsp_if.source                   response,
    input  logic                         cfg_write,
    input  logic [wegs_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [wegs_pkg::DataW-1:0]   cfg_data
);
    import wegs_pkg::*;

    wegs_cmd_t    cmd;
    wegs_status_t status;

    // Sequencer.
    wegs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_func   (request.func),
        .out_ready (response.ready),
        .status    (status),
        .cmd       (cmd),
        .in_ready  (request.ready),
        .out_valid (response.valid)
    );

    // Grid memories and update pipeline.
    wegs_dp #(
        .GRID_SIZE    (GRID_SIZE),
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .row       (request.row),
        .col       (request.col),
        .cmd       (cmd),
        .status    (status),
        .height    (response.height),
        .rate      (response.rate)
    );

endmodule

FILE: rtl/core/wegs_checker.sv
module wegs_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [wegs_pkg::DataW-1:0]   out_height,
    input logic signed [wegs_pkg::DataW-1:0]   out_rate
);

    // An accepted item closes the input and its result is not ready at once.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready && !out_valid)
        else $error("input open or result shown right after an accept");

    // No new item is taken while a result waits.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input open while a result is pending");

    // Each item yields exactly one result.
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid)
        else $error("result repeated after it was taken");

    // A stalled result holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_height) && $stable(out_rate))
        else $error("stalled result changed");

endmodule

bind wave_equation_grid_step wegs_checker u_wegs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (request.valid),
    .in_ready   (request.ready),
    .out_valid  (response.valid),
    .out_ready  (response.ready),
    .out_height (response.height),
    .out_rate   (response.rate)
);
